### hw/rtl/ptd_pkg.sv
// ptd_pkg: shared types and constants for the periodic task dispatcher
// no dependencies
package ptd_pkg;

    typedef enum logic [3:0] {
        OP_STEP       = 4'd0,
        OP_TICK       = 4'd1,
        OP_REGISTER   = 4'd2,
        OP_UNREGISTER = 4'd3,
        OP_PAUSE      = 4'd4,
        OP_RESUME     = 4'd5,
        OP_SLEEP      = 4'd6,
        OP_WAKE       = 4'd7,
        OP_QUERY      = 4'd8,
        OP_SEND       = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SEARCH
    } state_t;

    localparam logic [7:0] RUNS_UNLIMITED = 8'hFF;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture command fields
        logic read;    // read slot table entry
        logic exec;    // apply the operation, build result
        logic search;  // scan one slot
        logic finish;  // present result
    } ptd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_search;
        logic search_done;
    } ptd_stat_t;

endpackage

### hw/rtl/ptd_ctrl.sv
// ptd_ctrl: sequencing state machine for the dispatcher
// depends on ptd_pkg
module ptd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ptd_pkg::ptd_stat_t stat,
    output ptd_pkg::ptd_cmd_t  cmd,
    output logic               busy
);
    import ptd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_search)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (stat.search_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/ptd_datapath.sv
// ptd_datapath: slot table, message queue and result registers
// depends on ptd_pkg
module ptd_datapath #(
    parameter int TASK_SLOTS = 16,
    parameter int MSG_DEPTH  = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ptd_pkg::ptd_cmd_t  cmd,
    output ptd_pkg::ptd_stat_t stat,
    input  logic [3:0]         opcode,
    input  logic [3:0]         slot,
    input  logic [7:0]         task_uid,
    input  logic [15:0]        period,
    input  logic [7:0]         run_limit,
    input  logic [15:0]        sleep_ticks,
    input  logic [15:0]        msg_value,
    output logic               done,
    output logic               dispatched,
    output logic [3:0]         task_slot,
    output logic               msg_valid,
    output logic [15:0]        msg_out,
    output logic               failed,
    output logic               sleeping
);
    import ptd_pkg::*;

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int QW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int TW = $clog2(TASK_SLOTS + 1);
    localparam int FW = $clog2(MSG_DEPTH + 1);

    // per-slot control bits
    logic [TASK_SLOTS-1:0] occ_reg;
    logic [TASK_SLOTS-1:0] en_reg;
    logic [7:0]            uid_reg [TASK_SLOTS];
    // table memories
    logic [15:0] per_mem   [TASK_SLOTS];
    logic [15:0] cnt_mem   [TASK_SLOTS];
    logic [7:0]  runs_mem  [TASK_SLOTS];
    logic [15:0] sleep_mem [TASK_SLOTS];
    logic [SW-1:0] qdest_mem [MSG_DEPTH];
    logic [15:0]   qval_mem  [MSG_DEPTH];

    logic [TW-1:0] total_reg;
    logic [SW-1:0] cur_reg;
    logic          tick_reg;
    logic [QW-1:0] qrd_reg;
    logic [QW-1:0] qwr_reg;
    logic [FW-1:0] qfill_reg;

    // captured transaction
    logic [3:0]  op_reg;
    logic [3:0]  slot_reg;
    logic [7:0]  uidin_reg;
    logic [15:0] perin_reg;
    logic [7:0]  limin_reg;
    logic [15:0] slpin_reg;
    logic [15:0] mval_reg;

    // read data
    logic [SW-1:0] tgt_reg;
    logic [15:0]   rd_per_reg;
    logic [15:0]   rd_cnt_reg;
    logic [7:0]    rd_runs_reg;
    logic [15:0]   rd_sleep_reg;
    logic [SW-1:0] rd_qdest_reg;
    logic [15:0]   rd_qval_reg;

    // search
    logic [SW-1:0] scan_reg;
    logic [TW-1:0] steps_reg;

    logic        done_reg;
    logic        disp_reg;
    logic [3:0]  tslot_reg;
    logic        mv_reg;
    logic [15:0] msg_reg;
    logic        fail_reg;
    logic        slp_reg;

    // lowest free slot, lowest uid match
    logic [SW-1:0] free_idx;
    logic          free_any;
    logic [SW-1:0] match_idx;
    logic          match_any;
    logic          slot_ok;
    logic [SW-1:0] slot_idx;
    logic [SW-1:0] scan_nxt;

    always_comb
    begin
        free_idx  = '0;
        free_any  = 1'b0;
        match_idx = '0;
        match_any = 1'b0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
            if (occ_reg[i] && uid_reg[i] == uidin_reg)
            begin
                match_idx = SW'(i);
                match_any = 1'b1;
            end
        end
    end

    assign slot_ok  = ({28'd0, slot_reg} < 32'(TASK_SLOTS)) && occ_reg[slot_idx];
    assign slot_idx = SW'(slot_reg);
    assign scan_nxt = (32'(scan_reg) == TASK_SLOTS - 1) ? '0 : scan_reg + SW'(1);

    // step decision on read data
    logic step_occ, step_due, pop;
    logic [7:0] runs_dec;
    assign step_occ = occ_reg[tgt_reg];
    assign step_due = rd_runs_reg != 8'd0 && rd_cnt_reg == 16'd0 && rd_sleep_reg == 16'd0;
    assign pop      = en_reg[tgt_reg] && qfill_reg != '0 && rd_qdest_reg == tgt_reg;
    assign runs_dec = rd_runs_reg - 8'd1;

    assign stat.need_search = op_reg == OP_STEP && total_reg != '0;
    assign stat.search_done = occ_reg[scan_reg] || 32'(steps_reg) >= TASK_SLOTS - 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            en_reg    <= '0;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                uid_reg[i] <= '0;
            end
            total_reg <= '0;
            cur_reg   <= '0;
            tick_reg  <= 1'b0;
            qrd_reg   <= '0;
            qwr_reg   <= '0;
            qfill_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.exec)
            begin
                case (op_reg)
                    OP_STEP:
                    begin
                        if (total_reg != '0 && step_occ)
                        begin
                            if (step_due)
                            begin
                                if (pop)
                                begin
                                    qrd_reg   <= (32'(qrd_reg) == MSG_DEPTH - 1) ? '0
                                                 : qrd_reg + QW'(1);
                                    qfill_reg <= qfill_reg - FW'(1);
                                end
                                if (rd_runs_reg != RUNS_UNLIMITED && runs_dec == 8'd0)
                                begin
                                    occ_reg[tgt_reg] <= 1'b0;
                                    en_reg[tgt_reg]  <= 1'b0;
                                    total_reg        <= total_reg - TW'(1);
                                end
                            end
                            else if (tick_reg)
                            begin
                                tick_reg <= 1'b0;
                            end
                        end
                    end
                    OP_TICK:
                    begin
                        tick_reg <= 1'b1;
                    end
                    OP_REGISTER:
                    begin
                        if (free_any)
                        begin
                            occ_reg[free_idx] <= 1'b1;
                            en_reg[free_idx]  <= 1'b1;
                            uid_reg[free_idx] <= uidin_reg;
                            total_reg         <= total_reg + TW'(1);
                        end
                    end
                    OP_UNREGISTER:
                    begin
                        if (slot_ok)
                        begin
                            occ_reg[slot_idx] <= 1'b0;
                            en_reg[slot_idx]  <= 1'b0;
                            total_reg         <= total_reg - TW'(1);
                        end
                    end
                    OP_PAUSE:
                    begin
                        if (slot_ok)
                        begin
                            en_reg[slot_idx] <= 1'b0;
                        end
                    end
                    OP_RESUME:
                    begin
                        if (slot_ok)
                        begin
                            en_reg[slot_idx] <= 1'b1;
                        end
                    end
                    OP_SEND:
                    begin
                        if (uidin_reg != 8'd0 && 32'(qfill_reg) < MSG_DEPTH && match_any)
                        begin
                            qwr_reg   <= (32'(qwr_reg) == MSG_DEPTH - 1) ? '0
                                         : qwr_reg + QW'(1);
                            qfill_reg <= qfill_reg + FW'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // a scan that finds no occupied slot returns the round-robin position to slot 0
            if (cmd.search && stat.search_done)
            begin
                cur_reg <= occ_reg[scan_reg] ? scan_reg : '0;
            end
        end
    end

    // memories and payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            slot_reg  <= slot;
            uidin_reg <= task_uid;
            perin_reg <= period;
            limin_reg <= run_limit;
            slpin_reg <= sleep_ticks;
            mval_reg  <= msg_value;
        end
        if (cmd.read)
        begin
            tgt_reg      <= (op_reg == OP_STEP) ? cur_reg : slot_idx;
            rd_per_reg   <= per_mem[(op_reg == OP_STEP) ? cur_reg : slot_idx];
            rd_cnt_reg   <= cnt_mem[(op_reg == OP_STEP) ? cur_reg : slot_idx];
            rd_runs_reg  <= runs_mem[(op_reg == OP_STEP) ? cur_reg : slot_idx];
            rd_sleep_reg <= sleep_mem[(op_reg == OP_STEP) ? cur_reg : slot_idx];
            rd_qdest_reg <= qdest_mem[qrd_reg];
            rd_qval_reg  <= qval_mem[qrd_reg];
        end
        if (cmd.exec)
        begin
            disp_reg  <= 1'b0;
            tslot_reg <= 4'd0;
            mv_reg    <= 1'b0;
            msg_reg   <= 16'd0;
            fail_reg  <= 1'b0;
            slp_reg   <= 1'b0;
            scan_reg  <= (32'(tgt_reg) == TASK_SLOTS - 1) ? '0 : tgt_reg + SW'(1);
            steps_reg <= '0;
            case (op_reg)
                OP_STEP:
                begin
                    if (total_reg != '0 && step_occ)
                    begin
                        if (step_due)
                        begin
                            if (en_reg[tgt_reg])
                            begin
                                disp_reg  <= 1'b1;
                                tslot_reg <= 4'(tgt_reg);
                                if (pop)
                                begin
                                    mv_reg  <= 1'b1;
                                    msg_reg <= rd_qval_reg;
                                end
                            end
                            if (rd_runs_reg != RUNS_UNLIMITED)
                            begin
                                runs_mem[tgt_reg] <= runs_dec;
                            end
                            cnt_mem[tgt_reg] <= rd_per_reg;
                        end
                        else if (tick_reg)
                        begin
                            if (rd_sleep_reg != 16'd0)
                            begin
                                sleep_mem[tgt_reg] <= rd_sleep_reg - 16'd1;
                            end
                            if (rd_cnt_reg != 16'd0)
                            begin
                                cnt_mem[tgt_reg] <= rd_cnt_reg - 16'd1;
                            end
                        end
                    end
                end
                OP_REGISTER:
                begin
                    if (free_any)
                    begin
                        per_mem[free_idx]   <= perin_reg;
                        cnt_mem[free_idx]   <= perin_reg;
                        runs_mem[free_idx]  <= limin_reg;
                        sleep_mem[free_idx] <= 16'd0;
                        tslot_reg           <= 4'(free_idx);
                    end
                    else
                    begin
                        fail_reg <= 1'b1;
                    end
                end
                OP_UNREGISTER:
                begin
                    fail_reg <= !slot_ok;
                end
                OP_SLEEP:
                begin
                    if (slot_ok)
                    begin
                        sleep_mem[slot_idx] <= slpin_reg;
                    end
                end
                OP_WAKE:
                begin
                    if (slot_ok)
                    begin
                        sleep_mem[slot_idx] <= 16'd0;
                    end
                end
                OP_QUERY:
                begin
                    slp_reg <= slot_ok && rd_sleep_reg != 16'd0;
                end
                OP_SEND:
                begin
                    if (uidin_reg != 8'd0 && 32'(qfill_reg) < MSG_DEPTH && match_any)
                    begin
                        qdest_mem[qwr_reg] <= match_idx;
                        qval_mem[qwr_reg]  <= mval_reg;
                    end
                    else
                    begin
                        fail_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.search && !stat.search_done)
        begin
            scan_reg  <= scan_nxt;
            steps_reg <= steps_reg + TW'(1);
        end
    end

    assign done       = done_reg;
    assign dispatched = disp_reg;
    assign task_slot  = tslot_reg;
    assign msg_valid  = mv_reg;
    assign msg_out    = msg_reg;
    assign failed     = fail_reg;
    assign sleeping   = slp_reg;

endmodule

### hw/rtl/periodic_task_dispatcher_unit.sv
// periodic_task_dispatcher_unit: top level, controller plus datapath
// depends on ptd_pkg, ptd_ctrl, ptd_datapath
//
// usage: raise start with opcode and operands while busy is low; the command
// is taken at that edge and busy rises the next cycle. every command returns
// exactly one result, shown for one cycle with done high: dispatched,
// task_slot, msg_valid, msg_out, failed, sleeping.
// all commands but step go through read, execute and result, as does a
// step on an empty table. a step on a non-empty table also scans forward
// one slot a cycle to find the next occupied slot before the result.
// one command at a time; busy falls in the cycle that done is shown.
// reset clears the slot occupancy, enables, user ids, queue pointers,
// tick flag and round-robin position; table payload needs no clearing.
// the receiver cannot stall: done is a one-cycle strobe.
module periodic_task_dispatcher_unit #(
    parameter int TASK_SLOTS = 16,
    parameter int MSG_DEPTH  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  opcode,
    input  logic [3:0]  slot,
    input  logic [7:0]  task_uid,
    input  logic [15:0] period,
    input  logic [7:0]  run_limit,
    input  logic [15:0] sleep_ticks,
    input  logic [15:0] msg_value,
    output logic        done,
    output logic        dispatched,
    output logic [3:0]  task_slot,
    output logic        msg_valid,
    output logic [15:0] msg_out,
    output logic        failed,
    output logic        sleeping
);
    import ptd_pkg::*;

    ptd_cmd_t  cmd;
    ptd_stat_t stat;

    ptd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ptd_datapath #(
        .TASK_SLOTS (TASK_SLOTS),
        .MSG_DEPTH  (MSG_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .slot        (slot),
        .task_uid    (task_uid),
        .period      (period),
        .run_limit   (run_limit),
        .sleep_ticks (sleep_ticks),
        .msg_value   (msg_value),
        .done        (done),
        .dispatched  (dispatched),
        .task_slot   (task_slot),
        .msg_valid   (msg_valid),
        .msg_out     (msg_out),
        .failed      (failed),
        .sleeping    (sleeping)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_msg_disp: assert property (@(posedge clk) disable iff (!rst_n)
        done && msg_valid |-> dispatched)
        else $error("message delivered without dispatch");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command taken but busy not raised");

endmodule
